### hdl/lfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfrd_pkg;

  localparam int BufferDepthDef = 64;
  localparam int MaxFrameDef    = 32;

  localparam logic [7:0] LinkZero = 8'h00;
  localparam logic [7:0] LinkMark = 8'hF0;
  localparam logic [7:0] MinLen   = 8'd6;

  typedef enum logic [2:0] {
    EV_BYTE    = 3'd0,
    EV_ACK     = 3'd1,
    EV_PARITY  = 3'd2,
    EV_LENGTH  = 3'd3,
    EV_LINK    = 3'd4,
    EV_TIMEOUT = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CFG_REMOTE  = 2'd0,
    CFG_LOCAL   = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_t;

  // Scan sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_RD,
    S_EVAL,
    S_CHK,
    S_CHK_END,
    S_EMIT,
    S_EMIT_WAIT,
    S_EVENT
  } state_t;

endpackage
`default_nettype wire

### hdl/link_frame_receiver_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake       | Payload
// input    | in        | valid / stall   | kind, rx_byte
// output   | out       | out_valid/stall | event_res, data, last
// config   | in        | cfg_we          | cfg_index, cfg_data
//
// Each transaction appends a byte or ticks the idle timer. A sequencer then scans
// the store with one registered read at a time, each header byte read in S_RD
// and evaluated in S_EVAL. A frame check folds one byte per cycle, and each
// emitted byte passes S_EMIT and then S_EMIT_WAIT; output stalls hold both.
// Reset is synchronous; the store needs no clearing.
// Output stall holds the sequencer; stall is high while a scan runs.
module link_frame_receiver_deframer_top
  import lfrd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BufferDepthDef,
  parameter int MAX_FRAME    = MaxFrameDef
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            stall,
  input  wire logic       kind,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [7:0]      data,
  output logic            last,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int EmitCap = (MAX_FRAME < 63) ? MAX_FRAME : 63;
  localparam logic [8:0] EmitMax = 9'(EmitCap);
  localparam logic [8:0] DepthLim = 9'(BUFFER_DEPTH);

  logic [7:0] remote_address, local_address, timeout_ticks;
  logic [7:0] mem [BUFFER_DEPTH];
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [7:0] idle_timer, idle_timer_next;

  state_t state, state_next;
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [7:0] b0, b2, b0_next, b2_next;
  logic [7:0] len, len_next, chk, chk_next, ck5, ck5_next;
  logic [2:0] ph, ph_next;
  logic [8:0] idx, idx_next;
  logic [2:0] ev, ev_next;
  logic       ov_next;
  logic [2:0] oe_next;
  logic [7:0] od_next;
  logic       ol_next;
  logic       acc;

  assign acc = valid && !stall;
  assign stall = (state != S_IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      remote_address <= 8'd1;
      local_address  <= 8'd2;
      timeout_ticks  <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REMOTE:  remote_address <= cfg_data;
        CFG_LOCAL:   local_address  <= cfg_data;
        CFG_TIMEOUT: timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (acc && !kind && count < CW'(BUFFER_DEPTH))
      mem[AW'(head + AW'(count))] <= rx_byte;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= '0; count <= '0; idle_timer <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next; head <= head_next; count <= count_next;
      idle_timer <= idle_timer_next; out_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    b0 <= b0_next; b2 <= b2_next;
    len <= len_next; chk <= chk_next; ck5 <= ck5_next;
    ph <= ph_next; idx <= idx_next; ev <= ev_next;
    event_res <= oe_next; data <= od_next; last <= ol_next;
  end

  // sequencer
  always_comb begin
    state_next = state; head_next = head; count_next = count;
    idle_timer_next = idle_timer;
    b0_next = b0; b2_next = b2;
    len_next = len; chk_next = chk; ck5_next = ck5;
    ph_next = ph; idx_next = idx; ev_next = ev;
    ov_next = out_valid && out_stall;
    oe_next = event_res; od_next = data; ol_next = last;
    rd_addr = AW'(head + AW'(idx));
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_TOP;
          if (!kind) begin
            if (count < CW'(BUFFER_DEPTH)) count_next = count + 1'b1;
          end else if (count != '0) begin
            if (idle_timer != 8'd0) begin
              idle_timer_next = idle_timer - 8'd1;
              if (idle_timer == 8'd1) begin
                head_next = '0; count_next = '0;
                ev_next = EV_TIMEOUT; state_next = S_EVENT;
              end
            end
          end else begin
            idle_timer_next = timeout_ticks;
          end
        end
      end
      S_TOP: begin
        if (count < CW'(4)) state_next = S_IDLE;
        else begin
          ph_next = 3'd0; idx_next = 9'd0; state_next = S_RD;
        end
      end
      // read header bytes 0..4, each read registered before it is evaluated
      S_RD: begin
        rd_addr = AW'(head + AW'(ph));
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (ph)
          3'd0: b0_next = rd_data;
          3'd2: b2_next = rd_data;
          3'd4: len_next = rd_data;
          default: ;
        endcase
        state_next = S_RD;
        ph_next = ph + 3'd1;
        if (ph == 3'd1) begin
          if (b0 == remote_address) begin
            if (rd_data != local_address) begin
              head_next = head + 1'b1; count_next = count - 1'b1;
              state_next = S_TOP;
            end else if (count < CW'(5)) state_next = S_IDLE;
            else ph_next = 3'd4;
          end else if (b0 != LinkZero || rd_data != LinkZero) begin
            head_next = head + 1'b1; count_next = count - 1'b1;
            state_next = S_TOP;
          end
        end else if (ph == 3'd3) begin
          if (b2 == LinkMark && rd_data == LinkMark) begin
            head_next = head + AW'(4); count_next = count - CW'(4);
            ev_next = EV_LINK; state_next = S_EVENT;
          end else begin
            head_next = head + 1'b1; count_next = count - 1'b1;
            state_next = S_TOP;
          end
        end else if (ph == 3'd4) begin
          if (rd_data < MinLen || {1'b0, rd_data} > DepthLim) begin
            head_next = head + AW'(2); count_next = count - CW'(2);
            ev_next = EV_LENGTH; state_next = S_EVENT;
          end else if (9'(count) < {1'b0, rd_data}) state_next = S_IDLE;
          else begin
            idle_timer_next = timeout_ticks;
            chk_next = 8'd0; idx_next = 9'd0; state_next = S_CHK;
          end
        end
      end
      // check walk: issue read of idx, fold previous read
      S_CHK: begin
        if (idx != 9'd0) begin
          if (idx - 9'd1 == 9'd5) ck5_next = rd_data;
          else chk_next = chk ^ rd_data;
        end
        idx_next = idx + 9'd1;
        if (idx + 9'd1 == {1'b0, len}) state_next = S_CHK_END;
      end
      S_CHK_END: begin
        if (~((idx - 9'd1 == 9'd5) ? chk : (chk ^ rd_data)) ==
            ((idx - 9'd1 == 9'd5) ? rd_data : ck5)) begin
          idx_next = 9'd0; state_next = S_EMIT;
        end else begin
          head_next = head + AW'(2); count_next = count - CW'(2);
          ev_next = EV_PARITY; state_next = S_EVENT;
        end
      end
      // emit frame bytes; read issued here, data lands next cycle
      S_EMIT: begin
        if (!ov_next) state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!ov_next) begin
          ov_next = 1'b1; oe_next = EV_BYTE; od_next = rd_data; ol_next = 1'b0;
          idx_next = idx + 9'd1;
          if (idx + 9'd1 >= {1'b0, len} || idx + 9'd1 >= EmitMax) begin
            head_next = head + AW'(len); count_next = count - CW'(len);
            ev_next = EV_ACK; state_next = S_EVENT;
          end else state_next = S_EMIT;
        end
      end
      S_EVENT: begin
        if (!ov_next) begin
          ov_next = 1'b1; oe_next = ev; od_next = 8'd0; ol_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // assertions
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BUFFER_DEPTH)) else $error("count overflow");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("output lost");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable({event_res, data, last}))
    else $error("stalled result changed");

endmodule
`default_nettype wire
